[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands. They sample on clk and hold off during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/idfs_pkg.sv]
// ----------------------------------------------------------------------------
// idfs_pkg
// Shared types and codes for the depth-first order engine.
// ----------------------------------------------------------------------------
package idfs_pkg;

  localparam int VERTEX_W = 6;

  typedef logic [VERTEX_W-1:0] vertex_t;

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_TRAVERSE = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_NOP      = 2'd3
  } action_t;

  // Register index as decoded from paddr[2]
  localparam logic REG_NUM_VERTICES = 1'b0;
  localparam logic REG_DIRECTED     = 1'b1;

  localparam logic [6:0] NUM_VERTICES_RESET = 7'd64;

  typedef struct packed {
    action_t action;
    vertex_t edge_from;
    vertex_t edge_to;
    vertex_t source;
  } cmd_t;

  typedef struct packed {
    vertex_t vertex;
    logic    has_vertex;
    logic    last;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_ADD_RD1,
    S_ADD_WR1,
    S_ADD_RD2,
    S_ADD_WR2,
    S_TRAV_INIT,
    S_POP,
    S_TCHK,
    S_VIS,
    S_NRD,
    S_NCHK,
    S_NVIS,
    S_FINISH
  } state_t;

endpackage

[rtl/core/idfs_ram.sv]
// ----------------------------------------------------------------------------
// idfs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module idfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/iterative_dfs_order.sv]
// ----------------------------------------------------------------------------
// iterative_dfs_order
// Adjacency-list graph store with a stack-based depth-first walk. Edges are
// appended per vertex; a walk emits vertices in first-pop order.
// ----------------------------------------------------------------------------
//  channel   | signals                              | transaction
//  ----------+--------------------------------------+--------------------------
//  command   | start, busy, cmd                     | start high, busy low
//  result    | rsp_valid, rsp                       | one cycle per rsp_valid
//  config    | psel penable pwrite paddr pwdata ... | APB access, no wait state
//
//  Add edge: dropped if either end is out of range, else one direction or both
//  directions, each a read-modify-write of the vertex count. Clear sweeps the
//  vertex-info RAM. Traverse: stack pops and list entries (a stale entry skips
//  its visited check) are paced by the single vertex-info RAM port that serves
//  both the popped vertex and every neighbor visited check.
//  After reset the vertex-info RAM is swept, busy high.
//  Results cannot be stalled; the final one follows the stack running empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iterative_dfs_order #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEGREE   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  idfs_pkg::cmd_t      cmd,
  output logic                rsp_valid,
  output idfs_pkg::rsp_t      rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import idfs_pkg::*;

  localparam int STACK_DEPTH = MAX_VERTICES * MAX_DEGREE;
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_DEGREE + 1);
  localparam int NAW = $clog2(STACK_DEPTH);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [VW-1:0] LAST_VIDX = VW'(MAX_VERTICES - 1);

  // Config registers
  logic [6:0] num_vertices;
  logic       directed;

  // Sequencer registers
  state_t          state, state_next;
  cmd_t            cmd_q, cmd_q_next;
  logic [SPW-1:0]  sp, sp_next;
  logic [CW-1:0]   k, k_next;
  logic [CW-1:0]   cnt, cnt_next;
  vertex_t         cur_v, cur_v_next;
  vertex_t         nbr, nbr_next;
  logic            pend_valid, pend_valid_next;
  vertex_t         pend_vertex, pend_vertex_next;
  logic [VW-1:0]   clr_idx, clr_idx_next;
  logic            rsp_valid_next;
  rsp_t            rsp_next;

  // RAM ports; vertex info word is {visited, count}
  logic            vram_we;
  logic [VW-1:0]   vram_waddr, vram_raddr;
  logic [CW:0]     vram_wdata, vram_rdata;
  logic            ntab_we;
  logic [NAW-1:0]  ntab_waddr, ntab_raddr;
  vertex_t         ntab_wdata, ntab_rdata;
  logic            stk_we;
  logic [SAW-1:0]  stk_waddr, stk_raddr;
  vertex_t         stk_wdata, stk_rdata;

  function automatic logic in_range(input vertex_t v);
    in_range = ({1'b0, v} < num_vertices) && (32'(v) < MAX_VERTICES);
  endfunction

  function automatic logic [VW-1:0] vidx(input vertex_t v);
    vidx = VW'(v);
  endfunction

  function automatic logic [NAW-1:0] nta(input vertex_t v, input logic [CW-1:0] idx);
    nta = NAW'(32'(vidx(v)) * MAX_DEGREE + 32'(idx));
  endfunction

  idfs_ram #(.WIDTH(CW + 1), .DEPTH(MAX_VERTICES)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  idfs_ram #(.WIDTH(VERTEX_W), .DEPTH(STACK_DEPTH)) u_ntab (
    .clk   (clk),
    .we    (ntab_we),
    .waddr (ntab_waddr),
    .wdata (ntab_wdata),
    .raddr (ntab_raddr),
    .rdata (ntab_rdata)
  );

  idfs_ram #(.WIDTH(VERTEX_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DIRECTED) ? {31'd0, directed} : {25'd0, num_vertices};

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices <= NUM_VERTICES_RESET;
      directed     <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_NUM_VERTICES: num_vertices <= pwdata[6:0];
        REG_DIRECTED:     directed     <= pwdata[0];
        default:          num_vertices <= num_vertices;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      sp         <= '0;
      clr_idx    <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      sp         <= sp_next;
      clr_idx    <= clr_idx_next;
      pend_valid <= pend_valid_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q       <= cmd_q_next;
    k           <= k_next;
    cnt         <= cnt_next;
    cur_v       <= cur_v_next;
    nbr         <= nbr_next;
    pend_vertex <= pend_vertex_next;
    rsp         <= rsp_next;
  end

  always_comb begin
    state_next       = state;
    cmd_q_next       = cmd_q;
    sp_next          = sp;
    k_next           = k;
    cnt_next         = cnt;
    cur_v_next       = cur_v;
    nbr_next         = nbr;
    pend_valid_next  = pend_valid;
    pend_vertex_next = pend_vertex;
    clr_idx_next     = clr_idx;
    rsp_valid_next   = 1'b0;
    rsp_next         = rsp;
    vram_we          = 1'b0;
    vram_waddr       = '0;
    vram_wdata       = '0;
    vram_raddr       = '0;
    ntab_we          = 1'b0;
    ntab_waddr       = '0;
    ntab_wdata       = '0;
    ntab_raddr       = '0;
    stk_we           = 1'b0;
    stk_waddr        = '0;
    stk_wdata        = '0;
    stk_raddr        = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd_q_next = cmd;
          unique case (cmd.action)
            ACT_ADD:      state_next = S_ADD_RD1;
            ACT_TRAVERSE: state_next = S_TRAV_INIT;
            ACT_CLEAR: begin
              state_next   = S_CLEAR;
              clr_idx_next = '0;
              sp_next      = '0;
            end
            ACT_NOP:      state_next = S_IDLE;
            default:      state_next = S_IDLE;
          endcase
        end
      end

      S_CLEAR: begin
        vram_we    = 1'b1;
        vram_waddr = clr_idx;
        vram_wdata = '0;
        if (clr_idx == LAST_VIDX) begin
          state_next = S_IDLE;
        end else begin
          clr_idx_next = clr_idx + 1'b1;
        end
      end

      S_ADD_RD1: begin
        vram_raddr = vidx(cmd_q.edge_from);
        if (in_range(cmd_q.edge_from) && in_range(cmd_q.edge_to)) begin
          state_next = S_ADD_WR1;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_ADD_WR1: begin
        if (32'(vram_rdata[CW-1:0]) < MAX_DEGREE) begin
          ntab_we    = 1'b1;
          ntab_waddr = nta(cmd_q.edge_from, vram_rdata[CW-1:0]);
          ntab_wdata = cmd_q.edge_to;
          vram_we    = 1'b1;
          vram_waddr = vidx(cmd_q.edge_from);
          vram_wdata = {vram_rdata[CW], vram_rdata[CW-1:0] + CW'(1)};
        end
        state_next = directed ? S_IDLE : S_ADD_RD2;
      end

      // Reverse edge; the read lands after the first write, so self-loops count twice
      S_ADD_RD2: begin
        vram_raddr = vidx(cmd_q.edge_to);
        state_next = S_ADD_WR2;
      end

      S_ADD_WR2: begin
        if (32'(vram_rdata[CW-1:0]) < MAX_DEGREE) begin
          ntab_we    = 1'b1;
          ntab_waddr = nta(cmd_q.edge_to, vram_rdata[CW-1:0]);
          ntab_wdata = cmd_q.edge_from;
          vram_we    = 1'b1;
          vram_waddr = vidx(cmd_q.edge_to);
          vram_wdata = {vram_rdata[CW], vram_rdata[CW-1:0] + CW'(1)};
        end
        state_next = S_IDLE;
      end

      S_TRAV_INIT: begin
        pend_valid_next = 1'b0;
        if (in_range(cmd_q.source)) begin
          stk_we     = 1'b1;
          stk_waddr  = '0;
          stk_wdata  = cmd_q.source;
          sp_next    = SPW'(1);
          state_next = S_POP;
        end else begin
          sp_next    = '0;
          state_next = S_FINISH;
        end
      end

      S_POP: begin
        if (sp == '0) begin
          state_next = S_FINISH;
        end else begin
          sp_next    = sp - 1'b1;
          stk_raddr  = SAW'(sp - 1'b1);
          state_next = S_TCHK;
        end
      end

      S_TCHK: begin
        cur_v_next = stk_rdata;
        vram_raddr = vidx(stk_rdata);
        state_next = in_range(stk_rdata) ? S_VIS : S_POP;
      end

      // First pop of an unvisited vertex: mark, emit the previous one, expand
      S_VIS: begin
        if (vram_rdata[CW]) begin
          state_next = S_POP;
        end else begin
          vram_we          = 1'b1;
          vram_waddr       = vidx(cur_v);
          vram_wdata       = {1'b1, vram_rdata[CW-1:0]};
          cnt_next         = vram_rdata[CW-1:0];
          k_next           = '0;
          if (pend_valid) begin
            rsp_valid_next      = 1'b1;
            rsp_next.vertex     = pend_vertex;
            rsp_next.has_vertex = 1'b1;
            rsp_next.last       = 1'b0;
          end
          pend_valid_next  = 1'b1;
          pend_vertex_next = cur_v;
          state_next       = S_NRD;
        end
      end

      S_NRD: begin
        ntab_raddr = nta(cur_v, k);
        state_next = (k == cnt) ? S_POP : S_NCHK;
      end

      S_NCHK: begin
        nbr_next   = ntab_rdata;
        vram_raddr = vidx(ntab_rdata);
        if (in_range(ntab_rdata)) begin
          state_next = S_NVIS;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_NRD;
        end
      end

      S_NVIS: begin
        if (!vram_rdata[CW] && (32'(sp) < STACK_DEPTH)) begin
          stk_we    = 1'b1;
          stk_waddr = SAW'(sp);
          stk_wdata = nbr;
          sp_next   = sp + 1'b1;
        end
        k_next     = k + 1'b1;
        state_next = S_NRD;
      end

      S_FINISH: begin
        rsp_valid_next = 1'b1;
        if (pend_valid) begin
          rsp_next.vertex     = pend_vertex;
          rsp_next.has_vertex = 1'b1;
        end else begin
          rsp_next.vertex     = '0;
          rsp_next.has_vertex = 1'b0;
        end
        rsp_next.last   = 1'b1;
        pend_valid_next = 1'b0;
        state_next      = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_empty_is_last, rsp_valid && !rsp.has_vertex, rsp.last, "empty result without last")
  `ASSERT_NEXT(a_busy_after_cmd, start && !busy && cmd.action != ACT_NOP, busy, "command not taken")
  `ASSERT_IMPL(a_rsp_source, rsp_valid, $past(state == S_VIS || state == S_FINISH), "stray result")
  `ASSERT_ALWAYS(a_idle_stack_empty, state != S_IDLE || sp == '0, "stack not empty when idle")

endmodule

[sim/iterative_dfs_order_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterative_dfs_order_test
// Self-checking bench for the depth-first order engine. Commands go in over
// start/busy, the graph mode is set over APB between phases, and every visit
// strobe is matched against a software walk of the same adjacency lists.
// ----------------------------------------------------------------------------
import idfs_pkg::*;

class visit_order_board;
  localparam int GRAPH_SIZE = 64;
  localparam int LIST_DEPTH = 16;
  localparam int PRINT_CAP  = 40;

  vertex_t     links    [GRAPH_SIZE][LIST_DEPTH];
  int unsigned adj_len  [GRAPH_SIZE];
  bit          seen     [GRAPH_SIZE];
  int unsigned span;
  bit          one_way;
  rsp_t        expected_visits [$];
  int unsigned mismatches, visits_checked;
  int unsigned adds, walks, empty_walks, clears, no_ops;

  function new();
    span    = GRAPH_SIZE;
    one_way = 1'b0;
    foreach (adj_len[i]) begin
      adj_len[i] = 0;
      seen[i]    = 1'b0;
    end
  endfunction

  function void set_mode(logic [6:0] count, logic dir);
    span    = (count > GRAPH_SIZE) ? GRAPH_SIZE : count;
    one_way = dir;
  endfunction

  function int unsigned pending();
    return expected_visits.size();
  endfunction

  function void append_neighbor(vertex_t v, vertex_t n);
    if (adj_len[v] < LIST_DEPTH) begin
      links[v][adj_len[v]] = n;
      adj_len[v]++;
    end
  endfunction

  function void walk_from(vertex_t root);
    vertex_t pile [$];
    vertex_t order [$];
    vertex_t v;
    rsp_t    r;
    if (root < span) pile.insert(pile.size(), root);
    while (pile.size() != 0) begin
      v = pile.pop_back();
      // already-visited pops are dropped without re-expanding
      if (v >= span || seen[v]) continue;
      seen[v] = 1'b1;
      order.insert(order.size(), v);
      for (int k = 0; k < adj_len[v]; k++)
        if (links[v][k] < span && !seen[links[v][k]])
          pile.insert(pile.size(), links[v][k]);
    end
    walks++;
    if (order.size() == 0) begin
      empty_walks++;
      r.vertex     = '0;
      r.has_vertex = 1'b0;
      r.last       = 1'b1;
      expected_visits.insert(expected_visits.size(), r);
    end
    foreach (order[i]) begin
      r.vertex     = order[i];
      r.has_vertex = 1'b1;
      r.last       = (i == order.size() - 1);
      expected_visits.insert(expected_visits.size(), r);
    end
  endfunction

  function void note_command(cmd_t c);
    case (c.action)
      ACT_ADD: begin
        adds++;
        if (c.edge_from < span && c.edge_to < span) begin
          append_neighbor(c.edge_from, c.edge_to);
          if (!one_way) append_neighbor(c.edge_to, c.edge_from);
        end
      end
      ACT_TRAVERSE: walk_from(c.source);
      ACT_CLEAR: begin
        clears++;
        foreach (adj_len[i]) begin
          adj_len[i] = 0;
          seen[i]    = 1'b0;
        end
      end
      default: no_ops++;
    endcase
  endfunction

  task report_mismatch(string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task check_visit(rsp_t got);
    rsp_t want;
    if (expected_visits.size() == 0) begin
      report_mismatch($sformatf("unexpected result vertex=%0d has_vertex=%0b last=%0b",
                                got.vertex, got.has_vertex, got.last));
      return;
    end
    want = expected_visits.pop_front();
    visits_checked++;
    if (got.vertex !== want.vertex)
      report_mismatch($sformatf("result %0d vertex: got %0d, expected %0d",
                                visits_checked, got.vertex, want.vertex));
    if (got.has_vertex !== want.has_vertex)
      report_mismatch($sformatf("result %0d has_vertex: got %0b, expected %0b",
                                visits_checked, got.has_vertex, want.has_vertex));
    if (got.last !== want.last)
      report_mismatch($sformatf("result %0d last: got %0b, expected %0b",
                                visits_checked, got.last, want.last));
  endtask
endclass

module iterative_dfs_order_test;
  localparam int SETTLE_CYCLES = 80;     // covers a full clear sweep
  localparam int STALL_LIMIT   = 20000;

  logic        clk;
  logic        rst     = 1'b1;
  logic        start   = 1'b0;
  logic        busy;
  cmd_t        cmd     = '0;
  logic        rsp_valid;
  rsp_t        rsp;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  visit_order_board board = new();
  bit          idle_on  = 1'b1;
  int unsigned settings = 0;

  iterative_dfs_order u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid) board.check_visit(rsp);
  end

  // watchdog: cycles with neither a command nor a result transaction
  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || rsp_valid) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("FAIL iterative_dfs_order");
    $finish;
  end

  function automatic cmd_t command(action_t a, vertex_t f, vertex_t t, vertex_t s);
    cmd_t c;
    c.action    = a;
    c.edge_from = f;
    c.edge_to   = t;
    c.source    = s;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    logic [31:0] raw;
    raw = $urandom;
    return cmd_t'(raw[$bits(cmd_t)-1:0]);
  endfunction

  // mostly in range, now and then anywhere in the 6-bit space
  function automatic vertex_t pick_vertex();
    if (board.span == 0 || $urandom_range(99) < 10) return vertex_t'($urandom_range(63));
    return vertex_t'($urandom_range(board.span - 1));
  endfunction

  task automatic issue(input cmd_t c);
    int unsigned gap;
    gap = (idle_on && $urandom_range(99) < 24) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    board.note_command(c);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic sel, input logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata & ((sel == REG_NUM_VERTICES) ? 32'h7f : 32'h1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== want)
      board.report_mismatch($sformatf("register at 0x%0h reads %0d, expected %0d",
                                      {sel, 2'b00}, got, want));
  endtask

  task automatic set_mode(input logic [6:0] count, input logic dir);
    write_reg(REG_NUM_VERTICES, {25'd0, count});
    write_reg(REG_DIRECTED, {31'd0, dir});
    board.set_mode(count, dir);
    settings++;
    check_reg(REG_NUM_VERTICES, {25'd0, count});
    check_reg(REG_DIRECTED, {31'd0, dir});
  endtask

  // mostly well-formed bursts: optional clear, a run of edge adds, then a few walks; now and then a random command
  task automatic run_phase(input logic [6:0] count, input logic dir,
                           input bit gaps, input int unsigned want);
    int unsigned sent;
    int unsigned n_add;
    cmd_t        c;
    drain_results();
    set_mode(count, dir);
    idle_on = gaps;
    sent    = 0;
    while (sent < want) begin
      if ($urandom_range(99) < 8) begin
        c = random_cmd();
        issue(c);
        if (c.action != ACT_NOP) sent++;
      end else begin
        if ($urandom_range(99) < 30) begin
          c = random_cmd();
          c.action = ACT_CLEAR;
          issue(c);
          sent++;
        end
        n_add = $urandom_range(1, (board.span < 8) ? 20 : 10);
        repeat (n_add) begin
          c = random_cmd();
          c.action    = ACT_ADD;
          c.edge_from = pick_vertex();
          c.edge_to   = pick_vertex();
          issue(c);
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          c = random_cmd();
          c.action = ACT_TRAVERSE;
          c.source = pick_vertex();
          issue(c);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);   // post-reset sweep

    check_reg(REG_NUM_VERTICES, {25'd0, NUM_VERTICES_RESET});
    check_reg(REG_DIRECTED, 32'd0);
    set_mode(7'd64, 1'b0);

    // undirected: field extremes, self-loop, no-op, revisits, clear
    issue(command(ACT_ADD, 6'd0, 6'd63, 6'd0));
    issue(command(ACT_ADD, 6'd63, 6'd63, 6'd0));
    issue(command(ACT_ADD, 6'd0, 6'd21, 6'd0));
    issue(command(ACT_ADD, 6'd42, 6'd0, 6'd0));
    issue(command(ACT_NOP, 6'd63, 6'd63, 6'd63));
    issue(command(ACT_ADD, 6'd1, 6'd40, 6'd0));
    issue(command(ACT_ADD, 6'd1, 6'd2, 6'd0));
    issue(command(ACT_TRAVERSE, 6'd0, 6'd0, 6'd0));
    issue(command(ACT_TRAVERSE, 6'd63, 6'd63, 6'd21));
    issue(command(ACT_TRAVERSE, 6'd0, 6'd0, 6'd5));
    issue(command(ACT_CLEAR, 6'd63, 6'd63, 6'd63));
    issue(command(ACT_TRAVERSE, 6'd0, 6'd0, 6'd63));
    issue(command(ACT_ADD, 6'd2, 6'd50, 6'd0));
    issue(command(ACT_ADD, 6'd2, 6'd3, 6'd0));

    // shrink the graph without clearing: out-of-range adds and stale neighbors
    drain_results();
    set_mode(7'd4, 1'b1);
    issue(command(ACT_ADD, 6'd3, 6'd5, 6'd0));
    issue(command(ACT_ADD, 6'd5, 6'd1, 6'd0));
    issue(command(ACT_ADD, 6'd3, 6'd1, 6'd0));
    issue(command(ACT_TRAVERSE, 6'd0, 6'd0, 6'd2));
    issue(command(ACT_TRAVERSE, 6'd0, 6'd0, 6'd63));
    issue(command(ACT_CLEAR, 6'd0, 6'd0, 6'd0));

    // random phases; two vertices fills lists, 127 saturates, 0 disables all
    run_phase(7'd2,   1'b0, 1'b1, 48);
    run_phase(7'd127, 1'b1, 1'b1, 48);
    run_phase(7'd64,  1'b0, 1'b0, 48);
    run_phase(7'd0,   1'b0, 1'b1, 48);
    run_phase(7'd9,   1'b1, 1'b1, 48);
    run_phase(7'd1,   1'b0, 1'b1, 48);
    run_phase(7'd33,  1'b0, 1'b1, 48);
    run_phase(7'd64,  1'b1, 1'b1, 48);

    drain_results();
    $display("Covered %0d commands: %0d edge adds, %0d walks (%0d empty), %0d clears, %0d no-ops",
             board.adds + board.walks + board.clears + board.no_ops,
             board.adds, board.walks, board.empty_walks, board.clears, board.no_ops);
    $display("Checked %0d visit results across %0d register settings, %0d mismatches",
             board.visits_checked, settings, board.mismatches);
    if (board.mismatches == 0) $display("PASS iterative_dfs_order");
    else $display("FAIL iterative_dfs_order");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/idfs_pkg.sv
rtl/core/idfs_ram.sv
rtl/core/iterative_dfs_order.sv
sim/iterative_dfs_order_test.sv
